[src/png_chunk_extractor_macros.svh]
// Assertion macros shared by the PNG chunk extractor RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PNG_CHUNK_EXTRACTOR_MACROS_SVH
`define PNG_CHUNK_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define PCE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Condition must never be true outside reset.
`define PCE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define PCE_ASSERT(lbl, clk, rst_n, prop)
`define PCE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[src/pce_pkg.sv]
// Types, constants and the byte-wide CRC-32 function for the PNG chunk extractor.
// No dependencies; imported by pce_parser and png_chunk_extractor.
package pce_pkg;

  // CRC-32 (reflected) and PNG framing constants.
  localparam logic [31:0] CRC_POLY       = 32'hedb8_8320;
  localparam logic [31:0] ALL_ONES       = 32'hffff_ffff;
  localparam logic [31:0] IEND_TYPE      = 32'h4945_4e44;
  localparam logic [33:0] CHUNK_OVERHEAD = 34'd12;

  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4e, 8'h47,
                                         8'h0d, 8'h0a, 8'h1a, 8'h0a};

  // Register reset values.
  localparam logic [31:0] MATCH_TYPE_RST  = 32'h676c_4173;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0100_0000;

  // Register map: one 32-bit register per word, selected by paddr[2].
  localparam int unsigned APB_AW = 3;
  localparam logic REG_MATCH_TYPE  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  // Result kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    PH_SIG   = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC   = 3'd4,
    PH_AFTER = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOT_PNG   = 4'd1,
    ST_TRUNCATED = 4'd2,
    ST_PAST_END  = 4'd3,
    ST_TOO_LARGE = 4'd4,
    ST_BAD_CRC   = 4'd5,
    ST_DUPLICATE = 4'd6,
    ST_TRAILING  = 4'd7,
    ST_NO_IEND   = 4'd8
  } status_e;

  // One result produced by the parser for a processed byte.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data;
    status_e    status;
    logic       found;
  } pce_res_t;

  // One byte through the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/pce_parser.sv]
// Chunk walker of the PNG chunk extractor: parse state, CRC and status decisions.
// Depends on pce_pkg and png_chunk_extractor_macros.svh.
`include "png_chunk_extractor_macros.svh"

module pce_parser import pce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  logic [7:0]  byte_i,
  input  logic        final_i,
  input  logic [31:0] match_type_i,
  input  logic [31:0] max_payload_i,
  output pce_res_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [32:0] cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic        found_q, found_d;
  logic        matched_q, matched_d;
  logic        iend_q, iend_d;
  logic        done_q, done_d;

  logic [33:0] pos;
  logic [33:0] pos_next;
  logic [33:0] total;
  logic [33:0] data_end;
  logic [31:0] type_base;
  logic [31:0] crc_base;
  logic        st_vld;
  status_e     st_code;
  logic        dat_vld;

  // Chunk positions, widened so that a full 32-bit length never wraps.
  assign pos      = {1'b0, cnt_q};
  assign pos_next = pos + 34'd1;
  assign data_end = {2'b00, len_q} + 34'd8;
  assign total    = (pos >= 34'd4) ? ({2'b00, len_q} + CHUNK_OVERHEAD) : CHUNK_OVERHEAD;
  assign type_base = (pos == 34'd4) ? 32'h0 : type_q;
  assign crc_base  = (pos == 34'd4) ? ALL_ONES : crc_q;

  // Next state and result for the byte being processed.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    type_d    = type_q;
    crc_d     = crc_q;
    scrc_d    = scrc_q;
    found_d   = found_q;
    matched_d = matched_q;
    iend_d    = iend_q;
    done_d    = done_q;
    st_vld    = 1'b0;
    st_code   = ST_OK;
    dat_vld   = 1'b0;

    if (step_en_i && !done_q) begin
      if (phase_q == PH_SIG) begin
        if (byte_i != PNG_SIG[cnt_q[2:0]]) begin
          st_vld  = 1'b1;
          st_code = ST_NOT_PNG;
        end else if (cnt_q[2:0] == 3'd7) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
          if (final_i) begin
            st_vld  = 1'b1;
            st_code = ST_NO_IEND;
          end
        end else begin
          cnt_d = cnt_q + 33'd1;
          if (final_i) begin
            st_vld  = 1'b1;
            st_code = ST_NOT_PNG;
          end
        end
      end else if (phase_q == PH_AFTER) begin
        st_vld  = 1'b1;
        st_code = ST_TRAILING;
      end else if (final_i && (pos_next < total)) begin
        // File ends before the chunk does.
        st_vld  = 1'b1;
        st_code = (pos_next < CHUNK_OVERHEAD) ? ST_TRUNCATED : ST_PAST_END;
      end else begin
        cnt_d = pos_next[32:0];
        if (pos < 34'd4) begin
          // Length field, big-endian.
          len_d   = {len_q[23:0], byte_i};
          phase_d = (pos == 34'd3) ? PH_TYPE : PH_LEN;
        end else if (pos < 34'd8) begin
          // Type field: starts the CRC.
          type_d = {type_base[23:0], byte_i};
          crc_d  = crc32_byte(crc_base, byte_i);
          if (pos == 34'd7) begin
            matched_d = (type_d == match_type_i);
            phase_d   = (len_q == 32'h0) ? PH_CRC : PH_DATA;
          end
        end else if (pos < data_end) begin
          // Payload byte: streamed when this is the first matched chunk in range.
          crc_d = crc32_byte(crc_q, byte_i);
          if (pos_next == data_end) begin
            phase_d = PH_CRC;
          end
          dat_vld = matched_q && !found_q && (len_q <= max_payload_i);
        end else begin
          scrc_d = {scrc_q[23:0], byte_i};
          if (pos_next >= total) begin
            // Chunk complete: check the matched chunk, then the IEND rule.
            if (matched_q && (len_q > max_payload_i)) begin
              st_vld  = 1'b1;
              st_code = ST_TOO_LARGE;
            end else if (matched_q && ((crc_q ^ ALL_ONES) != scrc_d)) begin
              st_vld  = 1'b1;
              st_code = ST_BAD_CRC;
            end else if (matched_q && found_q) begin
              st_vld  = 1'b1;
              st_code = ST_DUPLICATE;
            end else begin
              if (matched_q) begin
                found_d = 1'b1;
              end
              if (type_q == IEND_TYPE) begin
                iend_d = 1'b1;
                if (final_i) begin
                  st_vld  = 1'b1;
                  st_code = ST_OK;
                end else begin
                  phase_d = PH_AFTER;
                end
              end else if (final_i) begin
                st_vld  = 1'b1;
                st_code = ST_NO_IEND;
              end else begin
                phase_d   = PH_LEN;
                cnt_d     = '0;
                len_d     = '0;
                scrc_d    = '0;
                matched_d = 1'b0;
              end
            end
          end
        end
      end
      if (st_vld) begin
        done_d = 1'b1;
      end
    end
  end

  // Result for the output register.
  always_comb begin
    res_o        = '0;
    res_o.valid  = st_vld || dat_vld;
    res_o.kind   = st_vld ? KIND_STATUS : KIND_DATA;
    res_o.data   = dat_vld ? byte_i : 8'h00;
    res_o.status = st_vld ? st_code : ST_OK;
    res_o.found  = st_vld && found_d;
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIG;
      cnt_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      crc_q     <= ALL_ONES;
      scrc_q    <= '0;
      found_q   <= 1'b0;
      matched_q <= 1'b0;
      iend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      type_q    <= type_d;
      crc_q     <= crc_d;
      scrc_q    <= scrc_d;
      found_q   <= found_d;
      matched_q <= matched_d;
      iend_q    <= iend_d;
      done_q    <= done_d;
    end
  end

  // Once a status is out, the parser stays silent.
  `PCE_ASSERT_NEVER(a_quiet_after_done, clk_i, rst_ni, done_q && res_o.valid)
  // The done flag is only set by emitting a status.
  `PCE_ASSERT(a_done_from_status, clk_i, rst_ni,
              $rose(done_q) |-> $past(res_o.valid && (res_o.kind == KIND_STATUS)))
  // A passed IEND chunk is followed only by the trailing-byte check.
  `PCE_ASSERT(a_iend_after, clk_i, rst_ni, (iend_q && !done_q) |-> (phase_q == PH_AFTER))

endmodule

[src/png_chunk_extractor.sv]
// Top level of the PNG chunk extractor: input and output registers, APB registers.
// Depends on pce_pkg, pce_parser and png_chunk_extractor_macros.svh.
`include "png_chunk_extractor_macros.svh"

// The block takes a PNG file one byte per request, with is_final_i set on the
// last byte, and accepts one byte every cycle unless the output stalls: the
// CRC-32 update and the chunk bookkeeping are a single combinational step
// between the input register and the result register, so the sustained rate
// is one byte per clock while out_ready_i applies no back-pressure.
// Payload bytes of the chunk whose type equals match_type (kind 0) are
// streamed before that chunk's CRC is known; exactly one status request
// (kind 1) follows, either at the first error or at the end of the file, after
// which the block ignores input until reset. Write match_type (address 0) and
// max_payload (address 4) only while no request is in flight; a new value is
// used from the next byte that needs it.
module png_chunk_extractor import pce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Byte input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              is_final_i,
  // Result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [7:0]        payload_byte_o,
  output logic [3:0]        status_o,
  output logic              found_flag_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_fin_q;
  logic        out_vld_q;
  pce_res_t    res;
  pce_res_t    res_q;
  logic        out_free;
  logic        step_en;
  logic [31:0] match_type_q;
  logic [31:0] max_payload_q;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_vld_q || out_ready_i;
  assign step_en    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_fin_q  <= is_final_i;
    end
  end

  pce_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (step_en),
    .byte_i        (in_byte_q),
    .final_i       (in_fin_q),
    .match_type_i  (match_type_q),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = res_q.kind;
  assign payload_byte_o = res_q.data;
  assign status_o       = res_q.status;
  assign found_flag_o   = res_q.found;

  // Configuration registers, written in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_type_q  <= MATCH_TYPE_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MATCH_TYPE:  match_type_q  <= pwdata;
        REG_MAX_PAYLOAD: max_payload_q <= pwdata;
        default:         match_type_q  <= match_type_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? max_payload_q : match_type_q;
  assign pready = 1'b1;

  // No result follows an accepted status.
  `PCE_ASSERT(a_status_last, clk_i, rst_ni,
              (out_valid_o && out_ready_i && (kind_o == KIND_STATUS)) |=> !out_valid_o)
  // A payload request carries a clear status and found flag.
  `PCE_ASSERT(a_data_clean, clk_i, rst_ni,
              (out_valid_o && (kind_o == KIND_DATA)) |-> ((status_o == ST_OK) && !found_flag_o))
  // A byte waiting behind a stalled output stays in the input register.
  `PCE_ASSERT(a_in_hold, clk_i, rst_ni,
              (in_vld_q && !out_free) |=>
              (in_vld_q && $stable(in_byte_q) && $stable(in_fin_q)))

endmodule
